[rtl/catmull_rom_stereo_resampler_defines.svh]
// Assertion macros used by the resampler checker.
`ifndef CATMULL_ROM_STEREO_RESAMPLER_DEFINES_SVH
`define CATMULL_ROM_STEREO_RESAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CRSR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CRSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/crsr_pkg.sv]
// Shared constants and types of the Catmull-Rom stereo resampler.
package crsr_pkg;

   // Phase fraction width default
   localparam int PHASE_FRAC_BITS_DEF = 16;

   // Rate step register, Q2.16
   localparam int               STEP_W     = 18;
   localparam logic [STEP_W-1:0] STEP_MIN   = 18'd32768;
   localparam logic [STEP_W-1:0] STEP_MAX   = 18'd131072;
   localparam logic [STEP_W-1:0] STEP_RESET = 18'd65536;

   // Sample and coefficient widths
   localparam int                      SAMPLE_W   = 16;
   localparam int                      COEF_W     = 20;
   localparam logic signed [SAMPLE_W-1:0] SAT_POS    = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   // Digit-serial multiplier: 8-bit digits, three digits per operand
   localparam int DIGIT_W    = 8;
   localparam int MUL_DIGITS = 3;
   localparam int MUL_OPND_W = DIGIT_W * MUL_DIGITS;

   // Output scale: 0.93 * 32767 = 93 * 32767 / 100
   localparam logic [MUL_OPND_W-1:0] SCALE_MULT = 24'd3047331;

   // Divide by 100 through a reciprocal, exact for quotient inputs below 2^22
   localparam int                 QUOT_IN_W    = 22;
   localparam int                 RECIP_W      = 23;
   localparam logic [RECIP_W-1:0] DIV100_RECIP = 23'd5368710;
   localparam int                 DIV100_SHIFT = 29;
   localparam int                 Q_W          = 15;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_STEP_Q16    = 1'b0,
      CSR_STEREO_MODE = 1'b1
   } csr_index_type;

endpackage

[rtl/catmull_rom_stereo_resampler.sv]
// Catmull-Rom cubic stereo resampler with a shared digit-serial multiplier.
//
// Input channel (req_*): one stereo sample pair in Q1.15 per transaction. In mono
// mode the right history takes the left sample. Each transaction causes zero, one
// or two output pairs on the result channel (rsp_*); rsp_last_of_run marks the
// final pair caused by an input transaction.
// Configuration (csr_*): index 0 is the Q2.16 rate step (clamped to 0.5..2.0),
// index 1 selects stereo (1) or mono (0). Write only while the block is idle.
// Sequence: the sequencer accepts the input, then computes each output pair one
// channel at a time, left then right, and hands the pair to the output register.
// The work is set by the 9-bit by (F+24)-bit multiplier, which steps through the
// three digits of the operand for each of the four products of a channel; a clipped
// channel skips the last.
// req_ready is high only while the sequencer is idle.
// Reset (synchronous, active high): histories cleared, phase 2.0, step 1.0,
// stereo mode, result channel empty.
// Stall: the finished pair sits in the output register; the sequencer holds the
// next pair until the register is taken, and a new input is accepted once the
// last pair of a transaction has reached the output register.
module catmull_rom_stereo_resampler
   import crsr_pkg::*;
#(
   parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [0:0]                 csr_index,
   input  logic [STEP_W-1:0]          csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic                       rsp_last_of_run
);

   localparam int F      = PHASE_FRAC_BITS;
   localparam int PW     = F + 2;
   localparam int WV     = F + 24;
   localparam int AW     = WV + MUL_OPND_W;
   localparam int PRODW  = WV + DIGIT_W + 1;
   localparam int QPW    = QUOT_IN_W + RECIP_W;
   localparam int DIG_CW = $clog2(MUL_DIGITS);

   localparam logic [PW-1:0]     PHASE_ONE   = PW'(1) << F;
   localparam logic [PW-1:0]     PHASE_RESET = PW'(2) << F;
   localparam logic [DIG_CW-1:0] LAST_DIG    = DIG_CW'(MUL_DIGITS - 1);
   localparam logic [WV-1:0]     SAT_LIM     =
      WV'(((64'd100 << (F + 16)) + 64'd92) / 64'd93);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COEF,
      ST_MUL,
      ST_NEXT,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_CUBIC,
      OP_QUAD,
      OP_LIN,
      OP_SCALE
   } op_type;

   // Control state
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic              chan_ff, chan_in;
   logic              second_ff, second_in;
   logic [DIG_CW-1:0] dig_ff, dig_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              stereo_ff, stereo_in;
   logic [PW-1:0]     phase_ff, phase_in;
   logic signed [SAMPLE_W-1:0] left_hist_ff [4];
   logic signed [SAMPLE_W-1:0] left_hist_in [4];
   logic signed [SAMPLE_W-1:0] right_hist_ff [4];
   logic signed [SAMPLE_W-1:0] right_hist_in [4];
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic signed [COEF_W-1:0]   c1_ff, c1_in;
   logic signed [COEF_W-1:0]   c2_ff, c2_in;
   logic signed [WV-1:0]       mv_ff, mv_in;
   logic [MUL_OPND_W-1:0]      tp_ff, tp_in;
   logic signed [AW-1:0]       acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic signed [SAMPLE_W-1:0] lres_ff, lres_in;
   logic signed [SAMPLE_W-1:0] rres_ff, rres_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Combinational helpers
   logic [STEP_W-1:0]          step_clamp;
   logic [PW-1:0]              step_f;
   logic [PW-1:0]              phase_sum;
   logic [MUL_OPND_W-1:0]      t_pad;
   logic signed [SAMPLE_W-1:0] y0, y1, y2, y3;
   logic signed [SAMPLE_W-1:0] right_pick;
   logic signed [COEF_W-1:0]   c1_calc, c2_calc, c3_calc;
   logic [DIGIT_W-1:0]         digit;
   logic signed [PRODW-1:0]    prod;
   logic signed [AW-1:0]       acc_base;
   logic signed [WV-1:0]       e_exact, e_floor, total;
   logic [WV-1:0]              mag;
   logic                       sat;
   logic [QUOT_IN_W-1:0]       y_div;
   logic [QPW-1:0]             q_prod;
   logic [Q_W-1:0]             q;
   logic                       res_done;
   logic signed [SAMPLE_W-1:0] res_val;
   logic                       last_pair;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_out    = rsp_left_ff;
   assign rsp_right_out   = rsp_right_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // Clamp the step and rescale it to the phase fraction width
   always_comb begin
      if (step_ff < STEP_MIN) begin
         step_clamp = STEP_MIN;
      end else if (step_ff > STEP_MAX) begin
         step_clamp = STEP_MAX;
      end else begin
         step_clamp = step_ff;
      end
      step_f    = PW'({step_clamp, 8'd0} >> (24 - F));
      phase_sum = phase_ff + step_f;
      last_pair = second_ff || (phase_sum >= PHASE_ONE);
      t_pad     = MUL_OPND_W'(phase_ff[F-1:0]) << (MUL_OPND_W - F);
   end

   // Pick the history of the channel in work and form the cubic coefficients
   always_comb begin
      y0 = chan_ff ? right_hist_ff[0] : left_hist_ff[0];
      y1 = chan_ff ? right_hist_ff[1] : left_hist_ff[1];
      y2 = chan_ff ? right_hist_ff[2] : left_hist_ff[2];
      y3 = chan_ff ? right_hist_ff[3] : left_hist_ff[3];
      c1_calc = COEF_W'(y2) - COEF_W'(y0);
      c2_calc = (COEF_W'(y0) <<< 1) - (COEF_W'(y1) <<< 2) - COEF_W'(y1)
              + (COEF_W'(y2) <<< 2) - COEF_W'(y3);
      c3_calc = (COEF_W'(y1) <<< 1) + COEF_W'(y1) - (COEF_W'(y2) <<< 1)
              - COEF_W'(y2) + COEF_W'(y3) - COEF_W'(y0);
      right_pick = stereo_ff ? req_right_in : req_left_in;
   end

   // Shared multiplier: one 8-bit digit of the operand per cycle, MSB first
   always_comb begin
      digit    = tp_ff[MUL_OPND_W-1 -: DIGIT_W];
      prod     = PRODW'(mv_ff) * PRODW'($signed({1'b0, digit}));
      acc_base = (dig_ff == '0) ? '0 : (acc_ff <<< DIGIT_W);
   end

   // Post-multiply terms: Horner steps, magnitude, saturation and divide by 100
   always_comb begin
      e_exact = WV'(acc_ff >>> (MUL_OPND_W - F));
      e_floor = WV'(acc_ff >>> MUL_OPND_W);
      total   = e_floor + (WV'(y1) <<< (F + 1));
      mag     = total[WV-1] ? WV'(-total) : WV'(total);
      sat     = (mag >= SAT_LIM);
      y_div   = acc_ff[F + 16 +: QUOT_IN_W];
      q_prod  = QPW'(y_div) * QPW'(DIV100_RECIP);
      q       = q_prod[DIV100_SHIFT +: Q_W];
   end

   // Sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      chan_in       = chan_ff;
      second_in     = second_ff;
      dig_in        = dig_ff;
      step_in       = step_ff;
      stereo_in     = stereo_ff;
      phase_in      = phase_ff;
      left_hist_in  = left_hist_ff;
      right_hist_in = right_hist_ff;
      rsp_valid_in  = rsp_valid_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      mv_in         = mv_ff;
      tp_in         = tp_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      lres_in       = lres_ff;
      rres_in       = rres_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_last_in   = rsp_last_ff;
      res_done      = 1'b0;
      res_val       = '0;

      // Drop the output pair once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_Q16:    step_in   = csr_write_data;
            CSR_STEREO_MODE: stereo_in = csr_write_data[0];
            default:         step_in   = step_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Advance both histories by one sample
               left_hist_in[0]  = left_hist_ff[1];
               left_hist_in[1]  = left_hist_ff[2];
               left_hist_in[2]  = left_hist_ff[3];
               left_hist_in[3]  = req_left_in;
               right_hist_in[0] = right_hist_ff[1];
               right_hist_in[1] = right_hist_ff[2];
               right_hist_in[2] = right_hist_ff[3];
               right_hist_in[3] = right_pick;
               if (phase_ff < PHASE_ONE) begin
                  chan_in   = 1'b0;
                  second_in = 1'b0;
                  state_in  = ST_COEF;
               end else begin
                  phase_in = phase_ff - PHASE_ONE;
               end
            end
         end
         ST_COEF: begin
            c1_in    = c1_calc;
            c2_in    = c2_calc;
            mv_in    = WV'(c3_calc);
            tp_in    = t_pad;
            dig_in   = '0;
            op_in    = OP_CUBIC;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            acc_in = acc_base + AW'(prod);
            tp_in  = tp_ff << DIGIT_W;
            dig_in = dig_ff + DIG_CW'(1);
            if (dig_ff == LAST_DIG) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            tp_in    = t_pad;
            dig_in   = '0;
            state_in = ST_MUL;
            case (op_ff)
               OP_CUBIC: begin
                  mv_in = e_exact + (WV'(c2_ff) <<< F);
                  op_in = OP_QUAD;
               end
               OP_QUAD: begin
                  mv_in = e_floor + (WV'(c1_ff) <<< F);
                  op_in = OP_LIN;
               end
               OP_LIN: begin
                  neg_in = total[WV-1];
                  if (sat) begin
                     res_done = 1'b1;
                     res_val  = total[WV-1] ? -SAT_POS : SAT_POS;
                  end else begin
                     mv_in = $signed(mag);
                     tp_in = SCALE_MULT;
                     op_in = OP_SCALE;
                  end
               end
               default: begin
                  res_done = 1'b1;
                  res_val  = neg_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
               end
            endcase
         end
         ST_EMIT: begin
            // Hold the pair until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = lres_ff;
               rsp_right_in = rres_ff;
               rsp_last_in  = last_pair;
               if (last_pair) begin
                  phase_in = (phase_sum >= PHASE_ONE) ? phase_sum - PHASE_ONE : '0;
                  state_in = ST_IDLE;
               end else begin
                  phase_in  = phase_sum;
                  second_in = 1'b1;
                  chan_in   = 1'b0;
                  state_in  = ST_COEF;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Store a finished channel result
      if (res_done) begin
         if (!chan_ff) begin
            lres_in  = res_val;
            chan_in  = 1'b1;
            state_in = ST_COEF;
         end else begin
            rres_in  = res_val;
            state_in = ST_EMIT;
         end
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      dig_ff       <= dig_in;
      c1_ff        <= c1_in;
      c2_ff        <= c2_in;
      mv_ff        <= mv_in;
      tp_ff        <= tp_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      lres_ff      <= lres_in;
      rres_ff      <= rres_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= 1'b0;
         second_ff    <= 1'b0;
         step_ff      <= STEP_RESET;
         stereo_ff    <= 1'b1;
         phase_ff     <= PHASE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            left_hist_ff[i]  <= '0;
            right_hist_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         chan_ff       <= chan_in;
         second_ff     <= second_in;
         step_ff       <= step_in;
         stereo_ff     <= stereo_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         left_hist_ff  <= left_hist_in;
         right_hist_ff <= right_hist_in;
      end
   end

endmodule

[rtl/crsr_checker.sv]
// Port-level checker for the resampler, bound to the top level.
`include "catmull_rom_stereo_resampler_defines.svh"

module crsr_checker
   import crsr_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_left_out,
   input logic signed [SAMPLE_W-1:0] rsp_right_out,
   input logic                       rsp_last_of_run
);

   logic pending_ff, pending_in;

   // Track a taken pair that was not the last of its run
   always_comb begin
      pending_in = pending_ff;
      if (rsp_valid && rsp_ready) begin
         pending_in = !rsp_last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `CRSR_ASSERT_IMPLY(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "result after reset")

   `CRSR_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out) && $stable(rsp_last_of_run), "stalled result changed")

   `CRSR_ASSERT_IMPLY(a_no_min_code, clock, reset, rsp_valid, (rsp_left_out != SAMPLE_MIN) && (rsp_right_out != SAMPLE_MIN), "output beyond clip range")

   `CRSR_ASSERT_IMPLY(a_run_bound, clock, reset, pending_ff && rsp_valid && rsp_ready, rsp_last_of_run, "third result in a run")

endmodule

bind catmull_rom_stereo_resampler crsr_checker u_crsr_checker (.*);

[tb/catmull_rom_stereo_resampler_tb.sv]
// Self-checking testbench for the Catmull-Rom stereo resampler.
`timescale 1ns / 100ps

module catmull_rom_stereo_resampler_tb;
   import crsr_pkg::*;

   localparam int PHASE_FRAC  = PHASE_FRAC_BITS_DEF;
   localparam int SETTLE_CYC  = 100;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } sample_pair_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       last;
   } out_pair_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [0:0]                 csr_index = CSR_STEP_Q16;
   logic [STEP_W-1:0]          csr_write_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_left_in = '0;
   logic signed [SAMPLE_W-1:0] req_right_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       rsp_last_of_run;
   logic                       rsp_hold = 1'b0;

   // Predictor state: configuration, history windows and the phase accumulator
   logic [STEP_W-1:0] step_cfg = STEP_RESET;
   logic              stereo_cfg = 1'b1;
   int                hist_left [4];
   int                hist_right [4];
   longint            phase_acc = longint'(2) << PHASE_FRAC;

   sample_pair_type pending_samples [$];
   out_pair_type    expected_pairs [$];
   bit           gaps_on = 1'b1;
   int           mismatch_count = 0;
   int           source_gap = 0;
   int           sink_gap = 0;

   catmull_rom_stereo_resampler DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_left_in     (req_left_in),
      .req_right_in    (req_right_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // Mostly short idle gaps, a few long ones; none while gaps are switched off
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (!gaps_on || roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(20, 4);
      return $urandom_range(90, 30);
   endfunction

   // One cubic point at fraction mu, scaled by 0.93, clipped, truncated toward zero
   function automatic logic signed [SAMPLE_W-1:0] catmull_point(
      input longint y0, input longint y1, input longint y2, input longint y3,
      input longint mu);
      longint      one, c1, c2, c3, acc, total;
      longint unsigned mag, den, q;
      int          qi;
      one = longint'(1) << PHASE_FRAC;
      c1 = y2 - y0;
      c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      c3 = 3 * (y1 - y2) + y3 - y0;
      // Horner steps; the second and third products by mu are floored
      acc = c3 * mu + c2 * one;
      acc = ((acc * mu) >>> PHASE_FRAC) + c1 * one;
      acc = (acc * mu) >>> PHASE_FRAC;
      total = y1 * 2 * one + acc;
      mag = (total < 0) ? -total : total;
      den = 64'd100 << (PHASE_FRAC + 16);
      if (mag * 93 >= den)
         q = 32767;
      else
         q = (mag * 93 * 32767) / den;
      qi = int'(q);
      return SAMPLE_W'((total < 0) ? -qi : qi);
   endfunction

   // Shift the new samples in and queue the output pairs they cause
   task automatic predict_pairs(input logic signed [SAMPLE_W-1:0] l_in,
                                input logic signed [SAMPLE_W-1:0] r_in);
      longint       one, stp;
      int           n;
      out_pair_type pair;
      one = longint'(1) << PHASE_FRAC;
      if (step_cfg < STEP_MIN)
         stp = STEP_MIN;
      else if (step_cfg > STEP_MAX)
         stp = STEP_MAX;
      else
         stp = step_cfg;
      // Rescale the Q2.16 step to the phase fraction width
      stp = (stp << PHASE_FRAC) >>> 16;
      for (int i = 0; i < 3; i++) begin
         hist_left[i]  = hist_left[i+1];
         hist_right[i] = hist_right[i+1];
      end
      hist_left[3]  = l_in;
      hist_right[3] = stereo_cfg ? r_in : l_in;
      n = 0;
      while (phase_acc < one && n < 2) begin
         pair.left  = catmull_point(hist_left[0], hist_left[1], hist_left[2],
                                    hist_left[3], phase_acc);
         pair.right = catmull_point(hist_right[0], hist_right[1], hist_right[2],
                                    hist_right[3], phase_acc);
         phase_acc += stp;
         n++;
         pair.last = !(phase_acc < one && n < 2);
         expected_pairs.push_back(pair);
      end
      if (phase_acc >= one)
         phase_acc -= one;
      else
         phase_acc = 0;
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Write one register; the block is idle whenever this is called
   task automatic write_csr(input csr_index_type idx, input logic [STEP_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_STEP_Q16)
         step_cfg = value;
      else
         stereo_cfg = value[0];
   endtask

   task automatic push_pair(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
      sample_pair_type item;
      item.left  = l;
      item.right = r;
      pending_samples.push_back(item);
   endtask

   // Hold until every transaction is taken and every expected pair has come
   task automatic wait_for_idle();
      while (pending_samples.size() != 0 || req_valid || expected_pairs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Random sample: extremes, full-range noise, or a bounded walk
   function automatic logic signed [SAMPLE_W-1:0] next_sample(input int prev);
      int roll, v;
      roll = $urandom_range(99);
      if (roll < 10) begin
         case ($urandom_range(3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      if (roll < 40) return SAMPLE_W'($urandom);
      v = prev + $urandom_range(8000) - 4000;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return SAMPLE_W'(v);
   endfunction

   // Driver: offer queued transactions, holding each until accepted
   always @(posedge clock) begin
      sample_pair_type item;
      if (reset) begin
         req_valid <= 1'b0;
         source_gap = 0;
      end else begin
         if (req_valid && req_ready)
            predict_pairs(req_left_in, req_right_in);
         if (!req_valid || req_ready) begin
            if (source_gap > 0) begin
               source_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               item = pending_samples.pop_front();
               req_valid    <= 1'b1;
               req_left_in  <= item.left;
               req_right_in <= item.right;
               source_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Back-pressure: one long hold on the result side after a number of inputs
   always @(posedge clock) begin
      int accepted_seen;
      int hold_cycles;
      bit hold_done;
      if (reset) begin
         accepted_seen = 0;
         hold_cycles = 0;
         hold_done = 1'b0;
         rsp_hold <= 1'b0;
      end else begin
         if (req_valid && req_ready) accepted_seen++;
         if (!hold_done && accepted_seen == 60) begin
            hold_cycles = 500;
            hold_done = 1'b1;
         end else if (hold_cycles > 0) begin
            hold_cycles--;
         end
         rsp_hold <= (hold_cycles != 0);
      end
   end

   // Monitor: compare each result transaction with the oldest expected pair
   always @(posedge clock) begin
      out_pair_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               report_mismatch($sformatf("unexpected pair L=%0d R=%0d last=%0b",
                                         rsp_left_out, rsp_right_out, rsp_last_of_run));
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_left_out !== want.left)
                  report_mismatch($sformatf("left_out %0d, want %0d",
                                            rsp_left_out, want.left));
               if (rsp_right_out !== want.right)
                  report_mismatch($sformatf("right_out %0d, want %0d",
                                            rsp_right_out, want.right));
               if (rsp_last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run %0b, want %0b",
                                            rsp_last_of_run, want.last));
            end
            sink_gap = pick_gap();
         end else if (sink_gap > 0) begin
            sink_gap--;
         end
         rsp_ready <= (sink_gap == 0) && !rsp_hold;
      end
   end

   // Stimulus: directed edge cases, then randomized configuration phases
   initial begin
      int prev_l, prev_r;
      logic [STEP_W-1:0] step_pick;
      for (int i = 0; i < 4; i++) begin
         hist_left[i]  = 0;
         hist_right[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: full-scale extremes and alternating bit patterns
      push_pair(16'sh7FFF, 16'sh8000);
      push_pair(16'sh8000, 16'sh7FFF);
      push_pair(16'sh0000, 16'sh0000);
      push_pair(16'shFFFF, 16'sh0001);
      push_pair(16'sh5555, 16'shAAAA);
      push_pair(16'shAAAA, 16'sh5555);
      wait_for_idle();

      // Step below range clamps to 0.5: two pairs per input, overshoot saturates
      write_csr(CSR_STEP_Q16, 18'd0);
      write_csr(CSR_STEREO_MODE, 18'd1);
      push_pair(16'sh0000, 16'sh0000);
      push_pair(16'sh7FFF, 16'sh8000);
      push_pair(16'sh7FFF, 16'sh8000);
      push_pair(16'sh0000, 16'sh0000);
      push_pair(16'sh0000, 16'sh0000);
      push_pair(16'sh8000, 16'sh7FFF);
      push_pair(16'sh8000, 16'sh7FFF);
      push_pair(16'sh0000, 16'sh0000);
      wait_for_idle();

      // Step above range clamps to 2.0; mono mode ignores the right input
      write_csr(CSR_STEP_Q16, 18'h3FFFF);
      write_csr(CSR_STEREO_MODE, 18'd0);
      push_pair(16'sd100, -16'sd5);
      push_pair(16'sh7FFF, 16'sd123);
      push_pair(16'sh8000, 16'shFFFF);
      push_pair(16'shFFFF, 16'sh7FFF);
      push_pair(16'sh0000, 16'sh8000);
      push_pair(16'sd12345, 16'sh0000);
      wait_for_idle();

      // Random phases over the step range and beyond both ends, in both channel modes
      prev_l = 0;
      prev_r = 0;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: step_pick = STEP_MIN;
            1: step_pick = STEP_MAX;
            3: step_pick = STEP_W'($urandom_range(32767));
            4: step_pick = STEP_W'($urandom_range(262143, 131073));
            default: step_pick = STEP_W'($urandom_range(131072, 32768));
         endcase
         gaps_on = (ph != 2);
         write_csr(CSR_STEP_Q16, step_pick);
         write_csr(CSR_STEREO_MODE, STEP_W'(ph % 2));
         for (int k = 0; k < 50; k++) begin
            push_pair(next_sample(prev_l), next_sample(prev_r));
            prev_l = pending_samples[$].left;
            prev_r = pending_samples[$].right;
         end
         wait_for_idle();
      end

      if (mismatch_count == 0 && expected_pairs.size() == 0) begin
         $display("catmull_rom_stereo_resampler_tb: PASS");
      end else begin
         $display("catmull_rom_stereo_resampler_tb: FAIL");
      end
      $finish;
   end

   // Run limit well beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("catmull_rom_stereo_resampler_tb: FAIL");
      $finish;
   end

endmodule
